/* rtl/gfp_pkg.sv */
// Shared types and constants for the group-of-four pooling block.
package gfp_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ELEMENTS_DEFAULT = 4096;
   localparam int VALUE_WIDTH_DEFAULT  = 16;

   // Samples pooled per group and the phase that closes a group
   localparam int         GROUP_SIZE = 4;
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_LAST  = 2'(GROUP_SIZE - 1);

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int EPS_W       = 13;
   localparam int CSR_DATA_W  = EPS_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENTS  = 1'd1;
   localparam logic [EPS_W-1:0]       EPS_RESET     = 13'd4096;

   // Pooling modes
   localparam logic MODE_MAX = 1'b0;
   localparam logic MODE_AVG = 1'b1;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Per-beat control that travels from front to back
   typedef struct packed {
      logic       mode;
      logic [1:0] phase;
      logic       last;
   } gfp_ctl_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } gfp_qstat_type;

   // Back-end pipeline status
   typedef struct packed {
      logic s2_valid;
      logic s2_emit;
   } gfp_bstat_type;

endpackage

/* rtl/gfp_req_if.sv */
// Input channel: one feature element per beat.
interface gfp_req_if #(
   parameter int VALUE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

/* rtl/gfp_rsp_if.sv */
// Result channel: one pooled element per beat.
interface gfp_rsp_if #(
   parameter int VALUE_WIDTH = 16,
   parameter int INDEX_WIDTH = 12
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] pooled_value;
   logic [1:0]                    winner_phase;
   logic [INDEX_WIDTH-1:0]        element_index;
   logic                          group_last;

   modport source (output valid, output pooled_value, output winner_phase,
                   output element_index, output group_last, input ready);
   modport sink   (input valid, input pooled_value, input winner_phase,
                   input element_index, input group_last, output ready);
endinterface

/* rtl/group_of_four_pooling.sv */
// Max or floored-average pooling of each element position over groups of four samples.
// Throughput: one beat per cycle, set by one store read and one write per cycle, unless a
// closing-phase beat waits on an untaken result; the previous write is forwarded when
// consecutive beats hit the same position.
// Reset (synchronous): counters, queue and pipeline clear; mode returns to max and the
// element count to 4096; the position store is not cleared and has no clearing pass.
module group_of_four_pooling import gfp_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT,
   parameter int VALUE_WIDTH  = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   gfp_req_if.sink                req_chan,
   gfp_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int POS_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CTL_W = $bits(gfp_ctl_type);
   localparam int QW    = VALUE_WIDTH + POS_W + CTL_W;

   gfp_qstat_type                 qstat;
   gfp_bstat_type                 bstat;
   logic                          push;
   logic signed [VALUE_WIDTH-1:0] push_value;
   logic [POS_W-1:0]              push_pos;
   gfp_ctl_type                   push_ctl;
   logic                          pop;
   logic [QW-1:0]                 pop_data;
   logic signed [VALUE_WIDTH-1:0] op_value;
   logic [POS_W-1:0]              op_pos;
   gfp_ctl_type                   op_ctl;

   gfp_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .qstat            (qstat),
      .push             (push),
      .push_value       (push_value),
      .push_pos         (push_pos),
      .push_ctl         (push_ctl)
   );

   gfp_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_value, push_pos, push_ctl}),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   assign op_value = pop_data[QW-1 -: VALUE_WIDTH];
   assign op_pos   = pop_data[CTL_W +: POS_W];
   assign op_ctl   = pop_data[CTL_W-1:0];

   gfp_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .op_value (op_value),
      .op_pos   (op_pos),
      .op_ctl   (op_ctl),
      .pop      (pop),
      .bstat    (bstat),
      .rsp_chan (rsp_chan)
   );

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   // A new result only comes from a closing-phase beat in the execute stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(bstat.s2_valid && bstat.s2_emit))
      else $error("result appeared without a closing-phase beat");

   // A queued beat enters an empty execute stage in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (!qstat.empty && !bstat.s2_valid) |=> bstat.s2_valid)
      else $error("queued beat not taken by the idle back end");

endmodule

/* rtl/gfp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic              read_en,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port; read returns the old word on a same-address collision
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

/* rtl/gfp_front.sv */
// Front end: configuration registers, position and phase counters, beat classification.
module gfp_front import gfp_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT,
   parameter int VALUE_WIDTH  = VALUE_WIDTH_DEFAULT,
   localparam int POS_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   gfp_req_if.sink                       req_chan,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_write_data,
   input  gfp_qstat_type                 qstat,
   output logic                          push,
   output logic signed [VALUE_WIDTH-1:0] push_value,
   output logic [POS_W-1:0]              push_pos,
   output gfp_ctl_type                   push_ctl
);

   logic             mode_ff;
   logic [EPS_W-1:0] eps_ff;
   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_eff;
   logic [CNT_W-1:0] pos_cur;
   logic [CNT_W-1:0] pos_next;
   logic             accept;

   // Clamp the element count to 1..MAX_ELEMENTS
   always_comb begin
      if (eps_ff == '0) begin
         count_eff = CNT_W'(1);
      end else if (32'(eps_ff) > 32'(MAX_ELEMENTS)) begin
         count_eff = CNT_W'(MAX_ELEMENTS);
      end else begin
         count_eff = CNT_W'(eps_ff);
      end
   end

   assign req_chan.ready = !qstat.full;
   assign accept         = req_chan.valid && !qstat.full;

   // Restart at position zero when the count shrank to or below the counter
   always_comb begin
      pos_cur  = (CNT_W'(pos_ff) >= count_eff) ? '0 : CNT_W'(pos_ff);
      pos_next = pos_cur + CNT_W'(1);
      if (pos_next >= count_eff) begin
         pos_in   = '0;
         phase_in = phase_ff + 2'd1;
      end else begin
         pos_in   = POS_W'(pos_next);
         phase_in = phase_ff;
      end
   end

   // Classify the beat for the back end
   assign push           = accept;
   assign push_value     = req_chan.sample_value;
   assign push_pos       = POS_W'(pos_cur);
   assign push_ctl.mode  = mode_ff;
   assign push_ctl.phase = phase_ff;
   assign push_ctl.last  = (pos_next == count_eff);

   // Hold configuration and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MAX;
         eps_ff   <= EPS_RESET;
         pos_ff   <= '0;
         phase_ff <= PHASE_FIRST;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_POOL_MODE: mode_ff <= csr_write_data[0];
               CSR_ELEMENTS:  eps_ff  <= csr_write_data[EPS_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            pos_ff   <= pos_in;
            phase_ff <= phase_in;
         end
      end
   end

endmodule

/* rtl/gfp_queue.sv */
// Short queue that decouples the front end from the back end.
module gfp_queue import gfp_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output gfp_qstat_type    qstat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [LVL_W-1:0] level_ff;

   assign qstat.full  = (level_ff == LVL_W'(QUEUE_DEPTH));
   assign qstat.empty = (level_ff == '0);
   assign pop_data    = entries_ff[rd_ptr_ff];

   // Store beats in arrival order
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and track the fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + LVL_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - LVL_W'(1);
         end
      end
   end

endmodule

/* rtl/gfp_back.sv */
// Back end: read-modify-write of the per-position store and the result register.
module gfp_back import gfp_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT,
   parameter int VALUE_WIDTH  = VALUE_WIDTH_DEFAULT,
   localparam int POS_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gfp_qstat_type                 qstat,
   input  logic signed [VALUE_WIDTH-1:0] op_value,
   input  logic [POS_W-1:0]              op_pos,
   input  gfp_ctl_type                   op_ctl,
   output logic                          pop,
   output gfp_bstat_type                 bstat,
   gfp_rsp_if.source                     rsp_chan
);

   localparam int ACC_W   = VALUE_WIDTH + 2;
   localparam int ENTRY_W = ACC_W + 2;

   // Execute stage
   logic                          s2_valid_ff;
   logic signed [VALUE_WIDTH-1:0] s2_value_ff;
   logic [POS_W-1:0]              s2_pos_ff;
   gfp_ctl_type                   s2_ctl_ff;

   // Last write, forwarded to a read that raced it
   logic                          wr_valid_ff;
   logic [POS_W-1:0]              wr_addr_ff;
   logic [ENTRY_W-1:0]            wr_data_ff;

   // Result register
   logic                          rsp_valid_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [1:0]                    rsp_win_ff;
   logic [POS_W-1:0]              rsp_index_ff;
   logic                          rsp_last_ff;

   logic [ENTRY_W-1:0]            ram_rdata;
   logic [ENTRY_W-1:0]            old_entry;
   logic signed [ACC_W-1:0]       acc_old;
   logic [1:0]                    win_old;
   logic signed [ACC_W-1:0]       value_ext;
   logic signed [ACC_W-1:0]       acc_new;
   logic [1:0]                    win_new;
   logic signed [ACC_W-1:0]       acc_shift;
   logic                          s2_emit;
   logic                          out_free;
   logic                          s2_go;
   logic                          advance;

   assign s2_emit  = (s2_ctl_ff.phase == PHASE_LAST);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s2_go    = s2_valid_ff && (!s2_emit || out_free);
   assign advance  = !s2_valid_ff || s2_go;
   assign pop      = advance && !qstat.empty;

   assign bstat.s2_valid = s2_valid_ff;
   assign bstat.s2_emit  = s2_emit;

   gfp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock      (clock),
      .write_en   (s2_go),
      .write_addr (s2_pos_ff),
      .write_data ({win_new, acc_new}),
      .read_en    (pop),
      .read_addr  (op_pos),
      .read_data  (ram_rdata)
   );

   // Take the previous write when it hit the same position
   assign old_entry = (wr_valid_ff && (wr_addr_ff == s2_pos_ff)) ? wr_data_ff : ram_rdata;
   assign acc_old   = old_entry[ACC_W-1:0];
   assign win_old   = old_entry[ACC_W +: 2];
   assign value_ext = ACC_W'(s2_value_ff);

   // Load on the first phase, then compare or accumulate
   always_comb begin
      if (s2_ctl_ff.phase == PHASE_FIRST) begin
         acc_new = value_ext;
         win_new = PHASE_FIRST;
      end else if (s2_ctl_ff.mode == MODE_MAX) begin
         if (value_ext > acc_old) begin
            acc_new = value_ext;
            win_new = s2_ctl_ff.phase;
         end else begin
            acc_new = acc_old;
            win_new = win_old;
         end
      end else begin
         acc_new = acc_old + value_ext;
         win_new = win_old;
      end
   end

   assign acc_shift = acc_new >>> 2;

   // Advance the execute stage and remember the last write
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s2_valid_ff <= pop;
         end
         if (s2_go) begin
            wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s2_value_ff <= op_value;
         s2_pos_ff   <= op_pos;
         s2_ctl_ff   <= op_ctl;
      end
      if (s2_go) begin
         wr_addr_ff <= s2_pos_ff;
         wr_data_ff <= {win_new, acc_new};
      end
   end

   // Load the result on the closing phase, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_go && s2_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s2_emit) begin
         if (s2_ctl_ff.mode == MODE_AVG) begin
            rsp_value_ff <= acc_shift[VALUE_WIDTH-1:0];
            rsp_win_ff   <= PHASE_FIRST;
         end else begin
            rsp_value_ff <= acc_new[VALUE_WIDTH-1:0];
            rsp_win_ff   <= win_new;
         end
         rsp_index_ff <= s2_pos_ff;
         rsp_last_ff  <= s2_ctl_ff.last;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pooled_value  = rsp_value_ff;
   assign rsp_chan.winner_phase  = rsp_win_ff;
   assign rsp_chan.element_index = rsp_index_ff;
   assign rsp_chan.group_last    = rsp_last_ff;

endmodule
